// File: rtl/udmg_pkg.sv
// Shared types and constants for the unsigned division recipe generator.
`default_nettype none

package udmg_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int SHIFT_BITS    = 5;

    typedef enum logic [2:0] {
        MODE_ZERO     = 3'd0,
        MODE_COMPARE  = 3'd1,
        MODE_SHIFT    = 3'd2,
        MODE_MULHI    = 3'd3,
        MODE_ADDFIX   = 3'd4,
        MODE_PRESHIFT = 3'd5
    } t_mode;

endpackage

`default_nettype wire

// File: rtl/unsigned_div_magic_generator_top.sv
// Top level: unsigned division recipe generator with a bit-serial restoring divider.
//
//  channel  | ports                                   | direction | transfer when
//  ---------+-----------------------------------------+-----------+-------------------
//  command  | start, busy, i_divisor                  | in        | start && !busy
//  result   | o_done, o_mode, o_multiplier,           | out       | o_done (one cycle)
//           | o_post_shift                            |           |
//
//  Zero and compare divisors go from idle straight to the done state; others first scan
//  d-1, one bit a cycle. Each shift trial runs two divisions and the final multiplier
//  one more; an even divisor with a wide multiplier repeats the search for d/2. The
//  single restoring divider, one quotient bit per cycle, sets the run time.
//  Synchronous active-low reset returns the sequencer to idle; the result strobe
//  cannot be held off, so busy stays high until the strobe cycle is over.
`default_nettype none

module unsigned_div_magic_generator_top
    import udmg_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [WORD_BITS-1:0]   i_divisor,
    output logic                        o_done,
    output logic [2:0]                  o_mode,
    output logic [WORD_BITS:0]          o_multiplier,
    output logic [SHIFT_BITS-1:0]       o_post_shift
);

    localparam int Q_BITS   = 2 * WORD_BITS;
    localparam int CNT_BITS = $clog2(Q_BITS + 1);
    localparam int L_BITS   = $clog2(WORD_BITS + 1);
    localparam logic [Q_BITS-1:0] Q_TOP  = Q_BITS'(1) << (Q_BITS - 1);
    localparam logic [Q_BITS-1:0] SLACK0 = Q_BITS'(1) << (WORD_BITS - 1);
    localparam logic [Q_BITS-1:0] SLACK1 = Q_BITS'(1) << WORD_BITS;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_LO   = 6'b000100,
        ST_HI   = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [WORD_BITS-1:0]    r_d, n_d;
    logic [WORD_BITS-1:0]    r_scan, n_scan;
    logic                    r_pow, n_pow;
    logic                    r_p, n_p;
    logic [L_BITS-1:0]       r_l, n_l;
    logic [L_BITS-1:0]       r_l0, n_l0;
    logic [CNT_BITS-1:0]     r_cnt, n_cnt;
    logic [WORD_BITS-1:0]    r_rem, n_rem;
    logic [Q_BITS-1:0]       r_q, n_q;
    logic [WORD_BITS:0]      r_lo, n_lo;
    t_mode                   r_mode, n_mode;
    logic [WORD_BITS:0]      r_mult, n_mult;
    logic [SHIFT_BITS-1:0]   r_shift, n_shift;

    logic [WORD_BITS:0]      w_t;
    logic [WORD_BITS:0]      w_diff;
    logic                    w_ge;
    logic [WORD_BITS-1:0]    w_rem_nx;
    logic [Q_BITS-1:0]       w_q_nx;
    logic [WORD_BITS:0]      w_quo;
    logic                    w_last;
    logic [L_BITS-1:0]       w_l_dec;
    logic [Q_BITS-1:0]       w_q_slack;
    logic [CNT_BITS-1:0]     w_cnt_base;
    logic [WORD_BITS-1:0]    w_div_m1;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign w_t        = {r_rem, r_q[Q_BITS-1]};
    assign w_diff     = w_t - {1'b0, r_d};
    assign w_ge       = (w_t >= {1'b0, r_d});
    assign w_rem_nx   = w_ge ? w_diff[WORD_BITS-1:0] : w_t[WORD_BITS-1:0];
    assign w_q_nx     = {r_q[Q_BITS-2:0], w_ge};
    assign w_quo      = w_q_nx[WORD_BITS:0];
    assign w_last     = (r_cnt == CNT_BITS'(1));
    assign w_l_dec    = r_l - L_BITS'(1);
    assign w_q_slack  = Q_TOP | (r_p ? SLACK1 : SLACK0);
    assign w_cnt_base = CNT_BITS'(WORD_BITS);
    assign w_div_m1   = i_divisor - WORD_BITS'(1);

    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_scan  = r_scan;
        n_pow   = r_pow;
        n_p     = r_p;
        n_l     = r_l;
        n_l0    = r_l0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_q     = r_q;
        n_lo    = r_lo;
        n_mode  = r_mode;
        n_mult  = r_mult;
        n_shift = r_shift;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_d     = i_divisor;
                    n_mult  = '0;
                    n_shift = '0;
                    n_p     = 1'b0;
                    n_l     = '0;
                    n_scan  = w_div_m1;
                    n_pow   = ((i_divisor & w_div_m1) == '0);
                    if (i_divisor == '0) begin
                        n_mode  = MODE_ZERO;
                        n_state = ST_DONE;
                    end else if (i_divisor[WORD_BITS-1]) begin
                        n_mode  = MODE_COMPARE;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan != '0) begin
                    n_scan = r_scan >> 1;
                    n_l    = r_l + L_BITS'(1);
                end else if (r_pow) begin
                    n_mode  = MODE_SHIFT;
                    n_shift = SHIFT_BITS'(r_l);
                    n_state = ST_DONE;
                end else begin
                    n_l0  = r_l;
                    n_rem = '0;
                    if (r_l == '0) begin
                        n_q     = w_q_slack;
                        n_cnt   = w_cnt_base + CNT_BITS'(1);
                        n_state = ST_FIN;
                    end else begin
                        n_q     = Q_TOP;
                        n_cnt   = w_cnt_base + CNT_BITS'(r_l);
                        n_state = ST_LO;
                    end
                end
            end
            ST_LO: begin
                n_rem = w_rem_nx;
                n_q   = w_q_nx;
                n_cnt = r_cnt - CNT_BITS'(1);
                if (w_last) begin
                    n_lo    = w_quo;
                    n_rem   = '0;
                    n_q     = w_q_slack;
                    n_cnt   = w_cnt_base + CNT_BITS'(r_l);
                    n_state = ST_HI;
                end
            end
            ST_HI: begin
                n_rem = w_rem_nx;
                n_q   = w_q_nx;
                n_cnt = r_cnt - CNT_BITS'(1);
                if (w_last) begin
                    n_rem = '0;
                    if (w_quo == r_lo) begin
                        n_q     = w_q_slack;
                        n_cnt   = w_cnt_base + CNT_BITS'(r_l) + CNT_BITS'(1);
                        n_state = ST_FIN;
                    end else if (w_l_dec == '0) begin
                        n_l     = w_l_dec;
                        n_q     = w_q_slack;
                        n_cnt   = w_cnt_base + CNT_BITS'(1);
                        n_state = ST_FIN;
                    end else begin
                        n_l     = w_l_dec;
                        n_q     = Q_TOP;
                        n_cnt   = w_cnt_base + CNT_BITS'(w_l_dec);
                        n_state = ST_LO;
                    end
                end
            end
            ST_FIN: begin
                n_rem = w_rem_nx;
                n_q   = w_q_nx;
                n_cnt = r_cnt - CNT_BITS'(1);
                if (w_last) begin
                    if (r_p) begin
                        n_mode  = MODE_PRESHIFT;
                        n_mult  = w_quo;
                        n_shift = SHIFT_BITS'(r_l);
                        n_state = ST_DONE;
                    end else if (!w_quo[WORD_BITS]) begin
                        n_mode  = MODE_MULHI;
                        n_mult  = w_quo;
                        n_shift = SHIFT_BITS'(r_l);
                        n_state = ST_DONE;
                    end else if (r_d[0]) begin
                        n_mode  = MODE_ADDFIX;
                        n_mult  = {1'b0, w_quo[WORD_BITS-1:0]};
                        n_shift = SHIFT_BITS'(w_l_dec);
                        n_state = ST_DONE;
                    end else begin
                        // even divisor: search again for d/2 at one bit less precision
                        n_d     = r_d >> 1;
                        n_p     = 1'b1;
                        n_l     = r_l0 - L_BITS'(1);
                        n_rem   = '0;
                        n_q     = Q_TOP;
                        n_cnt   = w_cnt_base + CNT_BITS'(r_l0 - L_BITS'(1));
                        n_state = ST_LO;
                    end
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_scan  <= n_scan;
        r_pow   <= n_pow;
        r_p     <= n_p;
        r_l     <= n_l;
        r_l0    <= n_l0;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_lo    <= n_lo;
        r_mode  <= n_mode;
        r_mult  <= n_mult;
        r_shift <= n_shift;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_done       = (r_state == ST_DONE);
    assign o_mode       = r_mode;
    assign o_multiplier = r_mult;
    assign o_post_shift = r_shift;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LO || r_state == ST_HI || r_state == ST_FIN) |-> (r_cnt != '0))
        else $error("divider running with empty bit count");

    a_shift_nomult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_mode == MODE_SHIFT || o_mode == MODE_ZERO)) |-> (o_multiplier == '0))
        else $error("multiplier set in shift or zero mode");

    a_addfix_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_mode == MODE_ADDFIX) |-> r_d[0])
        else $error("add-fixup recipe for an even divisor");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the unsigned division recipe generator.
`timescale 1ns / 1ps

module tb_top
    import udmg_pkg::*;
;

    localparam int QUIET_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 8400;

    typedef struct packed {
        logic [31:0] divisor;
        t_mode       mode;
        logic [32:0] multiplier;
        logic [4:0]  post_shift;
    } t_recipe;

    class recipe_scoreboard;
        t_recipe recipe_q[$];
        int      errors;

        static function int unsigned bit_len(bit [63:0] x);
            int unsigned n;
            n = 0;
            while (x != 0) begin
                x = x >> 1;
                n++;
            end
            return n;
        endfunction

        static function bit [63:0] magic_high(bit [63:0] d, int unsigned l, int unsigned prec);
            return ((64'd1 << (32 + l)) + (64'd1 << (l + 32 - prec))) / d;
        endfunction

        // smallest post-shift with a valid multiplier
        static function int unsigned pick_shift(bit [63:0] d, int unsigned prec,
                                                output bit [63:0] mult);
            int unsigned l;
            bit [63:0]   lo;
            l = bit_len(d - 1);
            while (l > 0) begin
                lo = (64'd1 << (32 + l - 1)) / d;
                if (lo == magic_high(d, l - 1, prec))
                    break;
                l--;
            end
            mult = magic_high(d, l, prec);
            return l;
        endfunction

        static function t_recipe derive_recipe(logic [31:0] div);
            t_recipe     r;
            bit [63:0]   d;
            bit [63:0]   m;
            int unsigned l;
            r.divisor    = div;
            r.mode       = MODE_ZERO;
            r.multiplier = '0;
            r.post_shift = '0;
            d = {32'd0, div};
            if (d[31]) begin
                r.mode = MODE_COMPARE;
            end else if (d != 0 && (d & (d - 1)) == 0) begin
                r.mode       = MODE_SHIFT;
                r.post_shift = 5'(bit_len(d) - 1);
            end else if (d != 0) begin
                l = pick_shift(d, 32, m);
                if (m < 64'h1_0000_0000) begin
                    r.mode       = MODE_MULHI;
                    r.multiplier = m[32:0];
                    r.post_shift = 5'(l);
                end else if (d[0]) begin
                    r.mode       = MODE_ADDFIX;
                    r.multiplier = 33'(m - 64'h1_0000_0000);
                    r.post_shift = 5'(l - 1);
                end else begin
                    l = pick_shift(d >> 1, 31, m);
                    r.mode       = MODE_PRESHIFT;
                    r.multiplier = m[32:0];
                    r.post_shift = 5'(l);
                end
            end
            return r;
        endfunction

        function void note_divisor(logic [31:0] div);
            recipe_q.push_back(derive_recipe(div));
        endfunction

        function int pending();
            return recipe_q.size();
        endfunction

        function void check_recipe(logic [2:0] mode, logic [32:0] mult, logic [4:0] shift);
            t_recipe e;
            if (recipe_q.size() == 0) begin
                $display("%0t: unexpected result: mode %0d multiplier %h post_shift %0d",
                         $time, mode, mult, shift);
                errors++;
                return;
            end
            e = recipe_q.pop_front();
            if (mode !== e.mode) begin
                $display("%0t: divisor %h mode: expected %0d, actual %0d",
                         $time, e.divisor, e.mode, mode);
                errors++;
            end
            if (mult !== e.multiplier) begin
                $display("%0t: divisor %h multiplier: expected %h, actual %h",
                         $time, e.divisor, e.multiplier, mult);
                errors++;
            end
            if (shift !== e.post_shift) begin
                $display("%0t: divisor %h post_shift: expected %0d, actual %0d",
                         $time, e.divisor, e.post_shift, shift);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_divisor;
    logic        o_done;
    logic [2:0]  o_mode;
    logic [32:0] o_multiplier;
    logic [4:0]  o_post_shift;

    recipe_scoreboard recipes;
    int               quiet_cycles;

    unsigned_div_magic_generator_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_divisor    (i_divisor),
        .o_done       (o_done),
        .o_mode       (o_mode),
        .o_multiplier (o_multiplier),
        .o_post_shift (o_post_shift)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            recipes.check_recipe(o_mode, o_multiplier, o_post_shift);
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_divisor(input logic [31:0] div, input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start     <= 1'b0;
            i_divisor <= $urandom;
            do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start     <= 1'b1;
        i_divisor <= div;
        do @(posedge i_clk); while (busy);
        recipes.note_divisor(div);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_divisor();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 3)
            return 32'd0;
        else if (sel < 8)
            return {1'b1, 31'($urandom)};
        else if (sel < 16)
            return 32'd1 << $urandom_range(31);
        else if (sel < 60)
            return $urandom_range(1000, 3);
        else if (sel < 80)
            return $urandom_range(32'h0010_0000, 1001);
        else
            return $urandom;
    endfunction

    logic [31:0] directed_divisors [22] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10, 32'd12, 32'd14,
        32'd25, 32'd641, 32'd1000, 32'h4000_0000, 32'h4000_0001, 32'h7FFF_FFFE,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
        32'hFFFF_FFFF
    };
    int idle_by_phase [4] = '{0, 82, 0, 32};

    initial begin
        recipes   = new;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_divisor = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_divisors[i])
            send_divisor(directed_divisors[i], 0);

        // hold off until every recipe is back
        start <= 1'b0;
        do @(negedge i_clk); while (recipes.pending() != 0);

        for (int p = 0; p < 4; p++)
            repeat (30) send_divisor(random_divisor(), idle_by_phase[p]);

        start <= 1'b0;
        while (recipes.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (recipes.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
